### rtl/core/psrl_pkg.sv
// ----------------------------------------------------------------------------
// psrl_pkg
// Shared constants and types for the per-source packet rate limiter.
// ----------------------------------------------------------------------------
package psrl_pkg;

    // table geometry
    localparam int TABLE_SETS = 16384;
    localparam int TABLE_WAYS = 4;
    localparam int COUNT_BITS = 17;

    localparam int SET_BITS = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
    localparam int WAY_BITS = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
    localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // frame classification
    localparam logic [15:0] MIN_FRAME_BYTES = 16'd34;
    localparam logic [15:0] IPV4_TYPE       = 16'h0800;
    localparam logic [15:0] RESET_THRESHOLD = 16'd1000;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // one way of a set
    typedef struct packed {
        logic                  valid;
        logic [31:0]           key;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    // one full set, read and written as a row
    typedef t_entry [TABLE_WAYS-1:0] t_row;

    // write request from the lookup logic to the table
    typedef struct packed {
        logic                en;
        logic [SET_BITS-1:0] set;
        t_row                row;
    } t_tbl_wr;

endpackage

### rtl/core/psrl_table.sv
// ----------------------------------------------------------------------------
// psrl_table
// Source table memory, one row per set, with a clearing pass after reset.
// ----------------------------------------------------------------------------
module psrl_table
    import psrl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [SET_BITS-1:0] i_rd_set,
    input  t_tbl_wr             i_wr,
    output t_row                o_rd_row,
    output logic                o_busy
);

    t_row                mem [TABLE_SETS];
    t_row                r_rd_row;
    logic                r_clr_active;
    logic [SET_BITS-1:0] r_clr_set;

    logic                w_we;
    logic [SET_BITS-1:0] w_waddr;
    t_row                w_wdata;

    // clear sweep, one row per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_set    <= '0;
        end else if (r_clr_active) begin
            if (r_clr_set == SET_BITS'(TABLE_SETS - 1)) begin
                r_clr_active <= 1'b0;
            end else begin
                r_clr_set <= r_clr_set + 1'b1;
            end
        end
    end

    // single write port shared by sweep and updates
    always_comb begin
        w_we    = r_clr_active | i_wr.en;
        w_waddr = r_clr_active ? r_clr_set : i_wr.set;
        w_wdata = r_clr_active ? '0 : i_wr.row;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_row <= mem[i_rd_set];
        end
    end

    assign o_rd_row = r_rd_row;
    assign o_busy   = r_clr_active;

    // no update request may collide with the sweep
    a_no_wr_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !i_wr.en)
        else $error("table update during clearing pass");

    // no lookup read during the sweep
    a_no_rd_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !i_rd_en)
        else $error("table read during clearing pass");

    // sweep index advances by one while active
    a_sweep_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clr_active && r_clr_set != SET_BITS'(TABLE_SETS - 1)) |=>
            (r_clr_set == $past(r_clr_set) + 1'b1))
        else $error("clearing pass skipped a row");

endmodule

### rtl/core/per_source_packet_rate_limiter.sv
// result: the table row is registered when a request is taken; the result register
//   loads from it in ST_LOOK once the output register is empty or being read
// flow: a new request is taken only after the table row read and the modify and
//   write-back of that row for the previous request
// reset: synchronous, active low; counters clear, threshold returns to 1000, and a
//   clearing pass over the 16384 sets (one set per cycle) precedes the first request
// ----------------------------------------------------------------------------
// per_source_packet_rate_limiter
// Per-source IPv4 frame rate limiter with a 4-way set-associative source table.
// ----------------------------------------------------------------------------
module per_source_packet_rate_limiter
    import psrl_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // frame_length[15:0], source_address[47:16]
    input  logic [15:0]  s_axis_tuser,   // ether_type[15:0]
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // ipv4_total[63:0], drop_total[127:64]
    output logic [2:0]   m_axis_tuser,   // verdict[0], counted[1], untracked[2]
    // threshold register
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [15:0]   r_threshold;
    logic [63:0]   r_ipv4_total, r_drop_total;
    logic          r_counted;
    logic [31:0]   r_addr;
    logic [SET_BITS-1:0] r_set;

    logic          r_out_valid;
    logic [127:0]  r_out_tdata;
    logic [2:0]    r_out_tuser;

    logic          w_accept, w_load, w_busy;
    logic [15:0]   w_len, w_etype, w_fold;
    logic [31:0]   w_in_addr;
    logic [SET_BITS-1:0] w_in_set;
    t_row          w_rd_row, w_new_row;
    t_tbl_wr       w_wr;

    logic          w_hit, w_free_found;
    logic [WAY_BITS-1:0] w_hit_way, w_free_way;
    logic          w_verdict, w_untracked;
    logic [COUNT_BITS-1:0] w_hit_count;

    // input unpacking and set selection
    assign w_len     = s_axis_tdata[15:0];
    assign w_in_addr = s_axis_tdata[47:16];
    assign w_etype   = s_axis_tuser;
    assign w_fold    = w_in_addr[31:16] ^ w_in_addr[15:0];
    assign w_in_set  = SET_BITS'(w_fold % TABLE_SETS);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_load        = (r_state == ST_LOOK) & (~r_out_valid | m_axis_tready);

    // source table
    psrl_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (w_accept),
        .i_rd_set (w_in_set),
        .i_wr     (w_wr),
        .o_rd_row (w_rd_row),
        .o_busy   (w_busy)
    );

    // state sequencing
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (!w_busy)  n_state = ST_IDLE;
            ST_IDLE:  if (w_accept) n_state = ST_LOOK;
            ST_LOOK:  if (w_load)   n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RESET_THRESHOLD;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr    <= w_in_addr;
            r_set     <= w_in_set;
            r_counted <= (w_len >= MIN_FRAME_BYTES) && (w_etype == IPV4_TYPE);
        end
    end

    // first matching way and first free way
    always_comb begin
        w_hit        = 1'b0;
        w_hit_way    = '0;
        w_free_found = 1'b0;
        w_free_way   = '0;
        for (int w = 0; w < TABLE_WAYS; w++) begin
            if (w_rd_row[w].valid) begin
                if (!w_hit && w_rd_row[w].key == r_addr) begin
                    w_hit     = 1'b1;
                    w_hit_way = WAY_BITS'(w);
                end
            end else if (!w_free_found) begin
                w_free_found = 1'b1;
                w_free_way   = WAY_BITS'(w);
            end
        end
    end

    // verdict and row update
    always_comb begin
        w_hit_count = w_rd_row[w_hit_way].count;
        w_verdict   = 1'b0;
        w_untracked = 1'b0;
        w_new_row   = w_rd_row;
        if (r_counted) begin
            if (w_hit) begin
                if (CMP_BITS'(w_hit_count) > CMP_BITS'(r_threshold)) begin
                    w_verdict = 1'b1;
                end else if (w_hit_count != COUNT_MAX) begin
                    w_new_row[w_hit_way].count = w_hit_count + 1'b1;
                end
            end else if (w_free_found) begin
                w_new_row[w_free_way].valid = 1'b1;
                w_new_row[w_free_way].key   = r_addr;
                w_new_row[w_free_way].count = COUNT_ONE;
            end else begin
                w_untracked = 1'b1;
            end
        end
        w_wr.en  = w_load & r_counted & (w_hit | w_free_found);
        w_wr.set = r_set;
        w_wr.row = w_new_row;
    end

    // running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ipv4_total <= '0;
            r_drop_total <= '0;
        end else if (w_load) begin
            if (r_counted) r_ipv4_total <= r_ipv4_total + 64'd1;
            if (w_verdict) r_drop_total <= r_drop_total + 64'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_tdata[63:0]   <= r_ipv4_total + {63'd0, r_counted};
            r_out_tdata[127:64] <= r_drop_total + {63'd0, w_verdict};
            r_out_tuser         <= {w_untracked, r_counted, w_verdict};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

    // a dropped or untracked frame was always counted
    a_flags_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((!r_out_tuser[0] && !r_out_tuser[2]) || r_out_tuser[1]))
        else $error("drop or untracked flag on an uncounted frame");

    // a frame is never both dropped and untracked
    a_drop_untracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_tuser[0] && r_out_tuser[2]))
        else $error("frame both dropped and untracked");

    // reported totals match the running counters after the update
    a_totals_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_out_tdata[63:0] == r_ipv4_total &&
                    r_out_tdata[127:64] == r_drop_total))
        else $error("reported totals differ from counters");

    // no request is taken before the clearing pass ends
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_axis_tready)
        else $error("request accepted during clearing pass");

endmodule

### verif/psrl_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psrl_scoreboard
// Watches the request, result and threshold ports of the rate limiter, keeps
// its own source table and counters, predicts one verdict per accepted request
// and compares every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module psrl_scoreboard
    import psrl_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic [47:0]  i_req_data,    // frame_length[15:0], source_address[47:16]
    input  logic [15:0]  i_req_user,    // ether_type[15:0]
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic [127:0] i_res_data,    // ipv4_total[63:0], drop_total[127:64]
    input  logic [2:0]   i_res_user,    // verdict[0], counted[1], untracked[2]
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data,
    output int           o_fail_count,
    output int           o_pending
);

    localparam int ENTRIES = TABLE_SETS * TABLE_WAYS;

    typedef struct packed {
        logic        verdict;
        logic        counted;
        logic        untracked;
        logic [63:0] ipv4_total;
        logic [63:0] drop_total;
    } t_frame_verdict;

    // shadow of the source table and counters
    bit                  tbl_valid [ENTRIES];
    bit [31:0]           tbl_key   [ENTRIES];
    bit [COUNT_BITS-1:0] tbl_count [ENTRIES];
    bit [63:0]           ipv4_count;
    bit [63:0]           drop_count;
    bit [15:0]           threshold;

    t_frame_verdict      verdicts_due [$];
    int                  fault_count = 0;

    // xor fold of the two address halves, reduced to a set number
    function automatic int unsigned set_index(logic [31:0] addr);
        logic [15:0] fold;
        fold = addr[15:0] ^ addr[31:16];
        return int'(fold) % TABLE_SETS;
    endfunction

    // classify one frame, update the shadow table and return its verdict
    function automatic t_frame_verdict rate_limit_frame(logic [15:0] len,
                                                        logic [15:0] etype,
                                                        logic [31:0] addr);
        t_frame_verdict v;
        int unsigned    base;
        int             hit;
        int             free_way;
        v = '0;
        if (len >= MIN_FRAME_BYTES && etype == IPV4_TYPE) begin
            v.counted  = 1'b1;
            ipv4_count = ipv4_count + 64'd1;
            base       = set_index(addr) * TABLE_WAYS;
            hit        = -1;
            free_way   = -1;
            for (int w = 0; w < TABLE_WAYS; w++) begin
                if (tbl_valid[base + w]) begin
                    if (hit < 0 && tbl_key[base + w] == addr)
                        hit = w;
                end else if (free_way < 0) begin
                    free_way = w;
                end
            end
            if (hit >= 0) begin
                // known source: drop once over the threshold, else count up
                if (tbl_count[base + hit] > threshold) begin
                    v.verdict  = 1'b1;
                    drop_count = drop_count + 64'd1;
                end else if (tbl_count[base + hit] != COUNT_MAX) begin
                    tbl_count[base + hit] = tbl_count[base + hit] + 1'b1;
                end
            end else if (free_way >= 0) begin
                tbl_valid[base + free_way] = 1'b1;
                tbl_key[base + free_way]   = addr;
                tbl_count[base + free_way] = COUNT_ONE;
            end else begin
                // set full, source left out of the table
                v.untracked = 1'b1;
            end
        end
        v.ipv4_total = ipv4_count;
        v.drop_total = drop_count;
        return v;
    endfunction

    // predict on request, compare on result, follow threshold writes
    always @(posedge i_clk) begin
        t_frame_verdict got;
        t_frame_verdict want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_key[i]   = '0;
                tbl_count[i] = '0;
            end
            ipv4_count = '0;
            drop_count = '0;
            threshold  = RESET_THRESHOLD;
            verdicts_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got.verdict    = i_res_user[0];
                got.counted    = i_res_user[1];
                got.untracked  = i_res_user[2];
                got.ipv4_total = i_res_data[63:0];
                got.drop_total = i_res_data[127:64];
                if (verdicts_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: result with no request pending: verdict=%0d %s",
                                 $time, got.verdict,
                                 $sformatf("counted=%0d untracked=%0d ipv4=%0d drops=%0d",
                                           got.counted, got.untracked, got.ipv4_total,
                                           got.drop_total));
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.verdict !== want.verdict || got.counted !== want.counted ||
                        got.untracked !== want.untracked ||
                        got.ipv4_total !== want.ipv4_total ||
                        got.drop_total !== want.drop_total) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display("%0t: result differs", $time);
                            $display("  expected verdict=%0d counted=%0d untracked=%0d %s",
                                     want.verdict, want.counted, want.untracked,
                                     $sformatf("ipv4=%0d drops=%0d",
                                               want.ipv4_total, want.drop_total));
                            $display("  actual   verdict=%0d counted=%0d untracked=%0d %s",
                                     got.verdict, got.counted, got.untracked,
                                     $sformatf("ipv4=%0d drops=%0d",
                                               got.ipv4_total, got.drop_total));
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                verdicts_due.push_back(rate_limit_frame(i_req_data[15:0], i_req_user,
                                                        i_req_data[47:16]));
            if (i_cfg_wr_en)
                threshold = i_cfg_wr_data;
        end
        o_pending    <= verdicts_due.size();
        o_fail_count <= fault_count;
    end

endmodule

### verif/tb_per_source_packet_rate_limiter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_source_packet_rate_limiter
// Drives frames into the rate limiter in random bursts through several drop
// thresholds, with a random and sometimes long stall on the result side; the
// scoreboard beside the block predicts and checks every verdict.
// ----------------------------------------------------------------------------
module tb_per_source_packet_rate_limiter;
    import psrl_pkg::*;

    localparam logic [15:0] ETH_ARP         = 16'h0806;
    localparam logic [15:0] ETH_IPV6        = 16'h86DD;
    localparam int          POOL_SIZE       = 24;
    localparam int          HOT_SETS        = 6;
    localparam int          HOLD_OFF_CYCLES = 300;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;    // frame_length[15:0], source_address[47:16]
    logic [15:0]  s_axis_tuser;    // ether_type[15:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;    // ipv4_total[63:0], drop_total[127:64]
    logic [2:0]   m_axis_tuser;    // verdict[0], counted[1], untracked[2]
    logic         i_cfg_wr_en;
    logic [15:0]  i_cfg_wr_data;

    int           fail_count;
    int           pending;
    bit           hold_req;

    // addresses reused often, crowded into a few sets
    logic [31:0]  addr_pool [POOL_SIZE];
    int unsigned  hot_sets  [HOT_SETS];

    per_source_packet_rate_limiter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    psrl_scoreboard u_scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_user    (s_axis_tuser),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_user    (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit, well above the clearing pass plus the slowest run
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random ready pattern, long hold-off on request
    initial begin
        int mode;
        int mode_left;
        mode          = 0;
        mode_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // address whose xor fold lands in the given set
    function automatic logic [31:0] addr_in_set(int unsigned set_no);
        logic [15:0] hi;
        logic [15:0] fold;
        hi   = 16'($urandom);
        fold = 16'(set_no + TABLE_SETS * $urandom_range(0, 65536 / TABLE_SETS - 1));
        return {hi, fold ^ hi};
    endfunction

    // replace some pool entries, mostly inside the crowded sets
    task automatic refresh_pool(int n);
        int slot;
        for (int i = 0; i < n; i++) begin
            slot = (n >= POOL_SIZE) ? i : $urandom_range(0, POOL_SIZE - 1);
            if ($urandom_range(0, 3) == 0)
                addr_pool[slot] = addr_in_set($urandom_range(0, TABLE_SETS - 1));
            else
                addr_pool[slot] = addr_in_set(hot_sets[$urandom_range(0, HOT_SETS - 1)]);
        end
    endtask

    // offer one request and hold it until accepted; starts and ends at a falling edge
    task automatic send_frame(logic [15:0] len, logic [15:0] etype, logic [31:0] addr);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {addr, len};
        s_axis_tuser  <= etype;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // drain every pending result before touching the threshold
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [15:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // random frames in bursts: mostly IPv4 from the pool, some noise
    task automatic run_random(int n);
        int          sent;
        int          burst;
        int          gap;
        logic [15:0] len;
        logic [15:0] etype;
        logic [31:0] addr;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < n; k++) begin
                addr = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                                   : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                if ($urandom_range(0, 99) < 80) begin
                    etype = IPV4_TYPE;
                    len   = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(34, 65535))
                                                        : 16'($urandom_range(34, 1518));
                end else begin
                    case ($urandom_range(0, 3))
                        0: begin
                            etype = IPV4_TYPE;
                            len   = 16'($urandom_range(0, 33));
                        end
                        1: begin
                            etype = 16'($urandom);
                            len   = 16'($urandom);
                        end
                        2: begin
                            etype = IPV4_TYPE ^ (16'd1 << $urandom_range(0, 15));
                            len   = 16'($urandom_range(34, 65535));
                        end
                        default: begin
                            etype = ($urandom_range(0, 1) != 0) ? ETH_IPV6 : ETH_ARP;
                            len   = 16'($urandom_range(34, 1518));
                        end
                    endcase
                end
                send_frame(len, etype, addr);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        logic [31:0] set0_a;
        logic [31:0] set0_b;
        logic [31:0] set0_c;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        hold_req      = 1'b0;
        for (int i = 0; i < HOT_SETS; i++)
            hot_sets[i] = $urandom_range(0, TABLE_SETS - 1);
        refresh_pool(POOL_SIZE);
        set0_a = addr_in_set(0);
        set0_b = addr_in_set(0);
        set0_c = addr_in_set(0);

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed frames at the reset threshold
        send_frame(16'd0,     IPV4_TYPE, 32'h0000_0000);   // too short
        send_frame(16'd33,    IPV4_TYPE, 32'h0A00_0001);   // one byte short
        send_frame(16'd34,    IPV4_TYPE, 32'h0000_0000);   // shortest counted, new
        send_frame(16'd34,    IPV4_TYPE, 32'h0000_0000);   // known source
        send_frame(16'hFFFF,  IPV4_TYPE, 32'hFFFF_FFFF);   // folds into set zero too
        send_frame(16'hFFFF,  16'hFFFF,  32'h1234_5678);   // not IPv4
        send_frame(16'hFFFF,  16'h0000,  32'h1234_5678);
        send_frame(16'd100,   16'h0801,  32'h1234_5678);
        send_frame(16'd100,   ETH_IPV6,  32'h1234_5678);
        // fill set zero, then overflow it
        send_frame(16'd64,    IPV4_TYPE, set0_a);
        send_frame(16'd64,    IPV4_TYPE, set0_b);
        send_frame(16'd64,    IPV4_TYPE, set0_c);          // set full, untracked
        send_frame(16'd1518,  IPV4_TYPE, set0_c);          // still untracked
        send_frame(16'd1518,  IPV4_TYPE, set0_a);          // known in a full set
        send_frame(16'd1518,  IPV4_TYPE, 32'h7FFF_FFFF);
        send_frame(16'd1518,  IPV4_TYPE, 32'h8000_0000);
        send_frame(16'd35,    IPV4_TYPE, 32'hFFFF_FFFF);
        send_frame(16'd33,    IPV4_TYPE, 32'hFFFF_FFFF);

        // lowest threshold: second frame of any tracked source drops
        wait_idle();
        write_threshold(16'd0);
        hold_req = 1'b1;
        run_random(250);

        wait_idle();
        write_threshold(16'd3);
        refresh_pool(8);
        run_random(250);

        // highest threshold: nothing drops, counts keep rising
        wait_idle();
        write_threshold(16'hFFFF);
        refresh_pool(8);
        hold_req = 1'b1;
        run_random(250);

        // threshold lowered under counts already stored
        wait_idle();
        write_threshold(16'd1);
        run_random(250);

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/psrl_pkg.sv
rtl/core/psrl_table.sv
rtl/core/per_source_packet_rate_limiter.sv
verif/psrl_scoreboard.sv
verif/tb_per_source_packet_rate_limiter.sv
